// File: sv/assert_macros.svh
// assertion helpers for the arbiter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("forbidden state");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: sv/psa_pkg.sv
`default_nettype none
package psa_pkg;
    localparam int GoalSlots = 8;
    localparam int AngleBits = 16;
    localparam int PrioW = 8;
    localparam int TimeW = 32;
    localparam int TolW = 15;
    localparam int StatusW = 3;
    localparam int CntW = 4;
    localparam int CfgIdxW = 3;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [StatusW-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [StatusW-1:0] ST_REPLACED = 3'd1;
    localparam logic [StatusW-1:0] ST_FULL = 3'd2;
    localparam logic [StatusW-1:0] ST_CANCELLED = 3'd3;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [StatusW-1:0] ST_TICK = 3'd5;

    localparam logic [CfgIdxW-1:0] REG_PAN_LOWER = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PAN_UPPER = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TILT_LOWER = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TILT_UPPER = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_IDLE_PAN = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_IDLE_TILT = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_ARRIVE_TOL = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_SERVE,
        S_OUT
    } t_state;
endpackage
`default_nettype wire

// File: sv/psa_ram.sv
`default_nettype none
module psa_ram #(
    parameter int Width = 8,
    parameter int Depth = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: sv/priority_setpoint_arbiter_unit.sv
// a submit or cancel goes through S_SCAN, S_WRITE and S_OUT; a tick goes through S_SCAN
// for each of its passes, then S_SERVE and S_OUT; an unused op gives no result
// one item at a time: the input waits while a result is held on the output
// the slot scan reads one memory entry a cycle; a tick scans twice, expiry then minimum
// reset: synchronous active low; clears the used bits, config to defaults, handshake idle
`default_nettype none
module priority_setpoint_arbiter_unit
    import psa_pkg::*;
#(
    parameter int GOAL_SLOTS = GoalSlots
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op, goal_priority, goal_pan, goal_tilt, goal_pan_speed, goal_tilt_speed,
    // goal_deadline, now_time, measured_pan, measured_tilt, zero pad
    input  wire logic [175:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status, ref_valid, ref_pan, ref_tilt, ref_pan_speed, ref_tilt_speed,
    // arrived, goal_active, served_priority, expired_count, zero pad
    output logic [87:0]       m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [15:0]  i_cfg_data
);
    localparam int SW = (GOAL_SLOTS > 1) ? $clog2(GOAL_SLOTS) : 1;
    localparam int EW = PrioW + 4*AngleBits + TimeW;
    localparam int CW = SW + 1;

    logic signed [AngleBits-1:0] r_pan_lo, r_pan_hi, r_tilt_lo, r_tilt_hi, r_idle_pan, r_idle_tilt;
    logic [TolW-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_lo <= 16'sh8000; r_pan_hi <= 16'sh7fff;
            r_tilt_lo <= 16'sh8000; r_tilt_hi <= 16'sh7fff;
            r_idle_pan <= '0; r_idle_tilt <= '0; r_tol <= 15'd205;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAN_LOWER:  r_pan_lo <= i_cfg_data;
                REG_PAN_UPPER:  r_pan_hi <= i_cfg_data;
                REG_TILT_LOWER: r_tilt_lo <= i_cfg_data;
                REG_TILT_UPPER: r_tilt_hi <= i_cfg_data;
                REG_IDLE_PAN:   r_idle_pan <= i_cfg_data;
                REG_IDLE_TILT:  r_idle_tilt <= i_cfg_data;
                REG_ARRIVE_TOL: r_tol <= i_cfg_data[TolW-1:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic [1:0] r_op;
    logic [PrioW-1:0] r_prio;
    logic [4*AngleBits+TimeW-1:0] r_goal;
    logic [TimeW-1:0] r_now;
    logic signed [AngleBits-1:0] r_mpan, r_mtilt;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic r_rd_vld;
    logic [SW-1:0] r_rd_idx;
    logic [GOAL_SLOTS-1:0] r_used;
    logic r_pass;          // tick: 0 expiry pass, 1 min pass
    logic r_hit, r_free;
    logic [SW-1:0] r_hit_idx, r_free_idx;
    logic [PrioW-1:0] r_best_prio;
    logic [CntW-1:0] r_exp;
    logic [EW-1:0] r_best;

    logic [EW-1:0] w_rdata;
    logic w_we;
    logic [SW-1:0] w_waddr;

    psa_ram #(.Width(EW), .Depth(GOAL_SLOTS)) u_slots (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr),
        .i_wdata({r_prio, r_goal}), .i_raddr(r_cnt[SW-1:0]), .o_rdata(w_rdata)
    );

    logic [PrioW-1:0] w_rprio;
    logic [TimeW-1:0] w_rdl;
    assign w_rprio = w_rdata[EW-1 -: PrioW];
    assign w_rdl = w_rdata[TimeW-1:0];

    logic w_in_acc, w_scan_done;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_scan_done = (r_cnt == CW'(GOAL_SLOTS)) && !r_rd_vld;
    assign w_we = (r_state == S_WRITE) && r_op == OP_SUBMIT && (r_hit || r_free);
    assign w_waddr = r_hit ? r_hit_idx : r_free_idx;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc && (s_axis_tdata[1:0] inside {OP_SUBMIT, OP_CANCEL, OP_TICK}))
                         n_state = S_SCAN;
            S_SCAN:  if (w_scan_done) n_state = (r_op == OP_TICK && r_pass) ? S_SERVE :
                                                (r_op == OP_TICK) ? S_SCAN : S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_SERVE: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // output side
    logic r_ovld;
    logic [87:0] r_odata;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = r_odata;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovld;

    logic signed [AngleBits-1:0] w_bpan, w_btilt, w_bps, w_bts, w_cp, w_ct;
    logic signed [AngleBits:0] w_ep, w_et;
    logic [AngleBits:0] w_mp, w_mt;
    logic w_at;
    assign w_bpan = r_best[TimeW+4*AngleBits-1 -: AngleBits];
    assign w_btilt = r_best[TimeW+3*AngleBits-1 -: AngleBits];
    assign w_bps = r_best[TimeW+2*AngleBits-1 -: AngleBits];
    assign w_bts = r_best[TimeW+AngleBits-1 -: AngleBits];

    always_comb begin
        w_cp = w_bpan;
        if (w_cp > r_pan_hi) w_cp = r_pan_hi;
        if (w_cp < r_pan_lo) w_cp = r_pan_lo;
        w_ct = w_btilt;
        if (w_ct > r_tilt_hi) w_ct = r_tilt_hi;
        if (w_ct < r_tilt_lo) w_ct = r_tilt_lo;
        w_ep = {w_cp[AngleBits-1], w_cp} - {r_mpan[AngleBits-1], r_mpan};
        w_et = {w_ct[AngleBits-1], w_ct} - {r_mtilt[AngleBits-1], r_mtilt};
        w_mp = w_ep[AngleBits] ? -w_ep : w_ep;
        w_mt = w_et[AngleBits] ? -w_et : w_et;
        w_at = (w_mp < {2'b0, r_tol}) && (w_mt < {2'b0, r_tol});
    end

    // slot entry layout: priority, pan, tilt, pan speed, tilt speed, deadline from the top down
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op <= s_axis_tdata[1:0];
            r_prio <= s_axis_tdata[9:2];
            r_goal <= {s_axis_tdata[25:10], s_axis_tdata[41:26], s_axis_tdata[57:42],
                       s_axis_tdata[73:58], s_axis_tdata[105:74]};
            r_now <= s_axis_tdata[137:106];
            r_mpan <= s_axis_tdata[153:138];
            r_mtilt <= s_axis_tdata[169:154];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_ovld <= 1'b0;
            r_cnt <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_ovld && m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0; r_rd_vld <= 1'b0; r_pass <= 1'b0;
                    r_hit <= 1'b0; r_free <= 1'b0; r_exp <= '0;
                end
                S_SCAN: begin
                    if (r_cnt != CW'(GOAL_SLOTS)) begin
                        r_rd_idx <= r_cnt[SW-1:0];
                        r_cnt <= r_cnt + 1'b1;
                        r_rd_vld <= 1'b1;
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (r_rd_vld) begin
                        if (r_op == OP_TICK && !r_pass) begin
                            if (r_used[r_rd_idx] && w_rdl != '0 && r_now > w_rdl) begin
                                r_used[r_rd_idx] <= 1'b0;
                                if (r_exp != 4'hf) r_exp <= r_exp + 1'b1;
                            end
                        end else if (r_op == OP_TICK) begin
                            if (r_used[r_rd_idx] && (!r_hit || w_rprio < r_best_prio)) begin
                                r_hit <= 1'b1; r_best_prio <= w_rprio; r_best <= w_rdata;
                            end
                        end else begin
                            if (r_used[r_rd_idx] && w_rprio == r_prio && !r_hit) begin
                                r_hit <= 1'b1; r_hit_idx <= r_rd_idx;
                            end
                            if (!r_used[r_rd_idx] && !r_free) begin
                                r_free <= 1'b1; r_free_idx <= r_rd_idx;
                            end
                        end
                    end
                    if (w_scan_done && r_op == OP_TICK && !r_pass) begin
                        r_pass <= 1'b1; r_cnt <= '0;
                    end
                end
                S_WRITE: begin
                    r_odata <= '0;
                    if (r_op == OP_SUBMIT) begin
                        if (r_hit) r_odata[2:0] <= ST_REPLACED;
                        else if (r_free) r_odata[2:0] <= ST_ACCEPTED;
                        else r_odata[2:0] <= ST_FULL;
                        if (r_hit || r_free) r_used[w_waddr] <= 1'b1;
                    end else begin
                        r_odata[2:0] <= r_hit ? ST_CANCELLED : ST_NOT_FOUND;
                        if (r_hit) r_used[r_hit_idx] <= 1'b0;
                    end
                end
                S_SERVE: begin
                    r_odata <= '0;
                    r_odata[2:0] <= ST_TICK;
                    r_odata[81:78] <= r_exp;
                    if (!r_hit) begin
                        r_odata[3] <= 1'b1;
                        r_odata[19:4] <= r_idle_pan;
                        r_odata[35:20] <= r_idle_tilt;
                    end else begin
                        r_odata[69] <= 1'b1;
                        r_odata[77:70] <= r_best_prio;
                        if (w_at) begin
                            r_odata[68] <= 1'b1;
                        end else begin
                            r_odata[3] <= 1'b1;
                            r_odata[19:4] <= w_cp;
                            r_odata[35:20] <= w_ct;
                            r_odata[51:36] <= w_bps;
                            r_odata[67:52] <= w_bts;
                        end
                    end
                end
                S_OUT: r_ovld <= 1'b1;
                default: ;
            endcase
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (r_state == S_OUT) |=> r_ovld)
    `ASSERT_NEVER(a_no_accept_busy, i_clk, i_rst_n, s_axis_tready && r_ovld)
    `ASSERT_IMPL(a_write_scan, i_clk, i_rst_n, w_we |-> $past(r_state) == S_SCAN)
endmodule
`default_nettype wire
